// ----- rtl/palette_rle_row_decoder_macros.svh -----
// Assertion macros for the palette RLE row decoder checker
`ifndef PALETTE_RLE_ROW_DECODER_MACROS_SVH
`define PALETTE_RLE_ROW_DECODER_MACROS_SVH

// property checked only outside reset
`define PRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every edge, reset included
`define PRD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/prd_pkg.sv -----
// Shared types and codes for the palette RLE row decoder
package prd_pkg;

  localparam logic [1:0] MODE_RGB565 = 2'd0;
  localparam logic [1:0] MODE_INDEX8 = 2'd1;
  localparam logic [1:0] MODE_INDEX1 = 2'd2;

  localparam logic CFG_PIXEL_MODE = 1'b0;
  localparam logic CFG_ROW_WIDTH  = 1'b1;

  localparam logic CMD_PALETTE = 1'b0;
  localparam logic CMD_ROW     = 1'b1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_OVERFLOW  = 3'd1;
  localparam logic [2:0] ST_SHORT     = 3'd2;
  localparam logic [2:0] ST_TRAILING  = 3'd3;
  localparam logic [2:0] ST_TOO_LONG  = 3'd4;

  // one decoded result, before or after the palette color is merged in
  typedef struct packed {
    logic        unit_valid;
    logic        use_mem;
    logic [15:0] color_one;
    logic [15:0] color_zero;
    logic [7:0]  bit_pattern;
    logic [7:0]  repeat_count;
    logic [3:0]  final_unit_pixels;
    logic        row_end;
    logic [2:0]  row_status;
  } result_t;

endpackage

// ----- rtl/prd_palette.sv -----
// Palette memory with one registered read port and shadow copies of entries 0 and 1
module prd_palette #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        we,
  input  logic [7:0]  waddr,
  input  logic [15:0] wdata,
  input  logic        re,
  input  logic [7:0]  raddr,
  output logic [15:0] rdata,
  output logic [15:0] pal0,
  output logic [15:0] pal1
);

  localparam int AW = $clog2(PALETTE_DEPTH);

  logic [15:0] mem [PALETTE_DEPTH];
  logic [15:0] mem_q;
  logic        oor_q;
  logic        w_in_range;
  logic        r_in_range;

  assign w_in_range = {1'b0, waddr} < 9'(PALETTE_DEPTH);
  assign r_in_range = {1'b0, raddr} < 9'(PALETTE_DEPTH);

  always_ff @(posedge clk) begin
    if (we && w_in_range) begin
      mem[waddr[AW-1:0]] <= wdata;
    end
    if (re) begin
      mem_q <= mem[raddr[AW-1:0]];
      oor_q <= !r_in_range;
    end
  end

  // entries 0 and 1 color the index1 mode, kept in flops for a parallel read
  always_ff @(posedge clk) begin
    if (we && waddr == 8'd0) begin
      pal0 <= wdata;
    end
    if (we && waddr == 8'd1) begin
      pal1 <= wdata;
    end
  end

  assign rdata = oor_q ? 16'd0 : mem_q;

endmodule

// ----- rtl/prd_row_ctrl.sv -----
// Row decode state: token parsing, unit counting and row status
module prd_row_ctrl #(
  parameter int MAX_ROW_BYTES = 512,
  parameter int MAX_WIDTH     = 4095
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic [7:0]        data_byte,
  input  logic              row_last,
  input  logic [1:0]        pixel_mode,
  input  logic [11:0]       row_width,
  input  logic [15:0]       pal0,
  input  logic [15:0]       pal1,
  output logic              res_valid,
  output prd_pkg::result_t  res
);

  localparam int BSW  = $clog2(MAX_ROW_BYTES + 1);
  localparam int WCAP = (MAX_WIDTH > 4095) ? 4095 : MAX_WIDTH;

  localparam logic [1:0] PH_TOKEN = 2'd0;
  localparam logic [1:0] PH_VALUE = 2'd1;
  localparam logic [1:0] PH_HIGH  = 2'd2;

  logic [11:0]    units;
  logic [BSW-1:0] bytes_seen;
  logic [1:0]     phase;
  logic [7:0]     values_left;
  logic           is_run;
  logic [7:0]     low_hold;
  logic [2:0]     err;

  logic [11:0]    units_next;
  logic [BSW-1:0] bytes_seen_next;
  logic [1:0]     phase_next;
  logic [7:0]     values_left_next;
  logic           is_run_next;
  logic [7:0]     low_hold_next;
  logic [2:0]     err_next;

  logic [1:0]  mode;
  logic [11:0] width;
  logic [11:0] expect_units;
  logic [11:0] width_m1;
  logic [7:0]  count;
  logic [7:0]  vl;
  logic [7:0]  rep;
  logic        unit;
  logic        eff_index1;
  prd_pkg::result_t r;

  always_comb begin
    mode  = (pixel_mode == 2'd3) ? prd_pkg::MODE_RGB565 : pixel_mode;
    width = (row_width > 12'(WCAP)) ? 12'(WCAP) : row_width;
    expect_units = (mode == prd_pkg::MODE_INDEX1) ?
                   12'((13'(width) + 13'd7) >> 3) : width;
    width_m1 = width - 12'd1;
    count    = {1'b0, data_byte[6:0]} + 8'd1;
    vl       = (values_left == 8'd0) ? 8'd1 : values_left;
    rep      = is_run ? vl : 8'd1;

    units_next       = units;
    bytes_seen_next  = bytes_seen;
    phase_next       = phase;
    values_left_next = values_left;
    is_run_next      = is_run;
    low_hold_next    = low_hold;
    err_next         = err;
    unit             = 1'b0;
    eff_index1       = 1'b0;
    r                = '0;

    if (bytes_seen >= BSW'(MAX_ROW_BYTES)) begin
      err_next = prd_pkg::ST_TOO_LONG;
    end else begin
      bytes_seen_next = bytes_seen + BSW'(1);
      if (err == prd_pkg::ST_OK) begin
        if (phase == PH_TOKEN) begin
          if (units >= expect_units) begin
            err_next = prd_pkg::ST_TRAILING;
          end else if (13'(units) + 13'(count) > 13'(expect_units)) begin
            err_next = prd_pkg::ST_OVERFLOW;
          end else begin
            is_run_next      = data_byte[7];
            values_left_next = count;
            phase_next       = PH_VALUE;
          end
        end else if (phase == PH_VALUE && mode == prd_pkg::MODE_RGB565) begin
          low_hold_next = data_byte;
          phase_next    = PH_HIGH;
        end else begin
          unit          = 1'b1;
          r.bit_pattern = 8'hff;
          if (phase == PH_HIGH) begin
            // a pending high byte always completes a direct color
            r.color_one = {data_byte, low_hold};
          end else if (mode == prd_pkg::MODE_INDEX8) begin
            r.use_mem = 1'b1;
          end else begin
            eff_index1    = 1'b1;
            r.color_one   = pal1;
            r.color_zero  = pal0;
            r.bit_pattern = data_byte;
          end
          values_left_next = is_run ? 8'd0 : vl - 8'd1;
          phase_next       = (values_left_next != 8'd0) ? PH_VALUE : PH_TOKEN;
          if (eff_index1) begin
            r.final_unit_pixels =
              (13'(units) + 13'(rep) == 13'(expect_units)) ?
              ({1'b0, width_m1[2:0]} + 4'd1) : 4'd8;
          end else begin
            r.final_unit_pixels = 4'd1;
          end
          r.repeat_count = rep;
          r.unit_valid   = 1'b1;
          units_next     = units + 12'(rep);
        end
      end
    end

    if (row_last) begin
      r.row_end = 1'b1;
      if (err_next != prd_pkg::ST_OK) begin
        r.row_status = err_next;
      end else if (phase_next != PH_TOKEN || units_next != expect_units) begin
        r.row_status = prd_pkg::ST_SHORT;
      end else begin
        r.row_status = prd_pkg::ST_OK;
      end
      units_next       = '0;
      bytes_seen_next  = '0;
      phase_next       = PH_TOKEN;
      values_left_next = '0;
      is_run_next      = 1'b0;
      low_hold_next    = '0;
      err_next         = prd_pkg::ST_OK;
    end
  end

  assign res_valid = unit || row_last;
  assign res       = r;

  always_ff @(posedge clk) begin
    if (rst) begin
      units       <= '0;
      bytes_seen  <= '0;
      phase       <= PH_TOKEN;
      values_left <= '0;
      is_run      <= 1'b0;
      low_hold    <= '0;
      err         <= prd_pkg::ST_OK;
    end else if (en) begin
      units       <= units_next;
      bytes_seen  <= bytes_seen_next;
      phase       <= phase_next;
      values_left <= values_left_next;
      is_run      <= is_run_next;
      low_hold    <= low_hold_next;
      err         <= err_next;
    end
  end

endmodule

// ----- rtl/palette_rle_row_decoder.sv -----
// An accepted word moves through the input, decode and output registers to the m side.
// Throughput: one word per cycle; input register, decode register and
// output register each advance when the stage after them is free.
// Row state and palette entries 0 and 1 feed the decode stage; the index8
// palette read lands beside the decode register and merges at the output.
// Reset clears valids, row state, pixel_mode (0), row_width (1), not the palette.
module palette_rle_row_decoder #(
  parameter int PALETTE_DEPTH = 256,
  parameter int MAX_ROW_BYTES = 512,
  parameter int MAX_WIDTH     = 4095
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // data_byte, palette_slot, palette_color
  input  logic        s_tuser,   // cmd
  input  logic        s_tlast,   // row_last
  output logic        m_tvalid,
  input  logic        m_tready,
  // color_one, color_zero, bit_pattern, repeat_count, final_unit_pixels,
  // row_status, zero pad
  output logic [55:0] m_tdata,
  output logic        m_tuser,   // unit_valid
  output logic        m_tlast,   // row_end
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data
);

  logic [1:0]  pixel_mode;
  logic [11:0] row_width;

  // input register
  logic        v0;
  logic [31:0] d0;
  logic        cmd0;
  logic        last0;

  // decode register
  logic             v1;
  prd_pkg::result_t s1;

  // output register
  logic             v2;
  prd_pkg::result_t s2;

  logic ready2;
  logic ready1;
  logic ready0;
  logic dec_en;
  logic pal_we;
  logic row_en;

  logic [15:0]      rdata;
  logic [15:0]      pal0;
  logic [15:0]      pal1;
  logic             res_valid;
  prd_pkg::result_t res;
  prd_pkg::result_t merged;

  assign ready2   = !v2 || m_tready;
  assign ready1   = !v1 || ready2;
  assign ready0   = !v0 || ready1;
  assign s_tready = ready0;

  assign dec_en = v0 && ready1;
  assign pal_we = dec_en && cmd0 == prd_pkg::CMD_PALETTE;
  assign row_en = dec_en && cmd0 == prd_pkg::CMD_ROW;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_mode <= prd_pkg::MODE_RGB565;
      row_width  <= 12'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        prd_pkg::CFG_PIXEL_MODE: pixel_mode <= cfg_data[1:0];
        prd_pkg::CFG_ROW_WIDTH:  row_width  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (ready0) begin
      v0 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && ready0) begin
      d0    <= s_tdata;
      cmd0  <= s_tuser;
      last0 <= s_tlast;
    end
  end

  prd_palette #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (d0[15:8]),
    .wdata (d0[31:16]),
    .re    (row_en),
    .raddr (d0[7:0]),
    .rdata (rdata),
    .pal0  (pal0),
    .pal1  (pal1)
  );

  prd_row_ctrl #(
    .MAX_ROW_BYTES(MAX_ROW_BYTES),
    .MAX_WIDTH    (MAX_WIDTH)
  ) u_row_ctrl (
    .clk        (clk),
    .rst        (rst),
    .en         (row_en),
    .data_byte  (d0[7:0]),
    .row_last   (last0),
    .pixel_mode (pixel_mode),
    .row_width  (row_width),
    .pal0       (pal0),
    .pal1       (pal1),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= row_en && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (row_en) begin
      s1 <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ready2) begin
      v2 <= v1;
    end
  end

  // merge the index8 palette color read during decode
  always_comb begin
    merged         = s1;
    merged.use_mem = 1'b0;
    if (s1.use_mem) begin
      merged.color_one = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (v1 && ready2) begin
      s2 <= merged;
    end
  end

  assign m_tvalid = v2;
  assign m_tuser  = s2.unit_valid;
  assign m_tlast  = s2.row_end;
  assign m_tdata  = {1'b0, s2.row_status, s2.final_unit_pixels, s2.repeat_count,
                     s2.bit_pattern, s2.color_zero, s2.color_one};

endmodule

// ----- rtl/prd_checker.sv -----
// Port-level assertions for the palette RLE row decoder, bound to the top level
`include "palette_rle_row_decoder_macros.svh"

module prd_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  `PRD_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid, "result word right after reset")
  `PRD_ASSERT(a_stall_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "stalled word changed")
  `PRD_ASSERT(a_bare_end, (m_tvalid && !m_tuser) |-> (m_tlast && m_tdata[51:0] == 52'd0), "word without unit is not a clean row end")
  `PRD_ASSERT(a_status_idle, (m_tvalid && !m_tlast) |-> (m_tdata[54:52] == prd_pkg::ST_OK), "status set before row end")
  `PRD_ASSERT(a_unit_fields, (m_tvalid && m_tuser) |-> (m_tdata[47:40] != 8'd0 && m_tdata[51:48] != 4'd0 && m_tdata[51:48] <= 4'd8), "unit with bad repeat or pixel count")

endmodule

bind palette_rle_row_decoder prd_checker u_prd_checker (.*);

// ----- tb/palette_rle_row_decoder_tb.sv -----
// Self-checking testbench for palette_rle_row_decoder: palette fill, directed table, then random rows
`timescale 1ns / 1ps

module palette_rle_row_decoder_tb;

  localparam int MAX_ROW_BYTES = 512;
  localparam int RAND_WORDS    = 1000;
  localparam int IDLE_LIMIT    = 3000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam logic [1:0] MODE_RGB565_ALT = 2'd3;

  typedef enum logic [1:0] {PH_TOKEN, PH_VALUE, PH_HIGH} phase_t;
  typedef enum logic [1:0] {ROW_PRED, ROW_NONE, ROW_TYPED, ROW_CFG} dir_kind_t;
  typedef enum {SH_GOOD, SH_CUT, SH_EXTRA, SH_OVER, SH_NOISE, SH_LONG} row_shape_t;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  data;
    logic        last;
    logic [7:0]  slot;
    logic [15:0] color;
  } in_word_t;

  typedef struct packed {
    logic        unit;
    logic [15:0] color_one;
    logic [15:0] color_zero;
    logic [7:0]  pattern;
    logic [7:0]  reps;
    logic [3:0]  fin_pixels;
    logic        row_end;
    logic [2:0]  status;
  } out_word_t;

  typedef struct packed {
    dir_kind_t   kind;
    in_word_t    w;
    out_word_t   res;
    logic        cfg_idx;
    logic [11:0] cfg_val;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  wire         s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        s_tlast = 1'b0;
  wire         m_tvalid;
  logic        m_tready = 1'b0;
  wire  [55:0] m_tdata;
  wire         m_tuser;
  wire         m_tlast;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [11:0] cfg_data = '0;

  palette_rle_row_decoder dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  int          errors = 0;
  int          idle_cycles = 0;
  bit          tx_burst = 1'b0;
  bit          rx_burst = 1'b0;
  bit          hold_req = 1'b0;
  out_word_t   pending_units[$];
  logic [7:0]  row_bytes[$];
  dir_row_t    dir_tab[$];
  out_word_t   want, got;

  // decoder model state
  logic [15:0] pal_mem [256];
  int unsigned p_units, p_bytes, p_left;
  phase_t      p_phase;
  logic        p_run;
  logic [7:0]  p_low;
  logic [2:0]  p_err;
  logic [1:0]  cur_mode;
  logic [11:0] cur_width;

  function automatic void clear_row_state();
    p_units = 0;
    p_bytes = 0;
    p_phase = PH_TOKEN;
    p_left  = 0;
    p_run   = 1'b0;
    p_low   = '0;
    p_err   = prd_pkg::ST_OK;
  endfunction

  // returns 1 when the word produces a result word
  function automatic bit decode_word(input in_word_t w, output out_word_t r);
    logic [1:0]  mode;
    int unsigned exp_units, count;
    bit          has_unit;
    mode = (cur_mode == MODE_RGB565_ALT) ? prd_pkg::MODE_RGB565 : cur_mode;
    exp_units = (mode == prd_pkg::MODE_INDEX1) ? (int'(cur_width) + 7) / 8 : int'(cur_width);
    r = '0;
    has_unit = 1'b0;
    if (w.cmd == prd_pkg::CMD_PALETTE) begin
      pal_mem[w.slot] = w.color;
      return 1'b0;
    end
    if (p_bytes >= MAX_ROW_BYTES) begin
      p_err = prd_pkg::ST_TOO_LONG;
    end else begin
      p_bytes++;
      if (p_err == prd_pkg::ST_OK) begin
        if (p_phase == PH_TOKEN) begin
          count = int'(w.data[6:0]) + 1;
          if (p_units >= exp_units) begin
            p_err = prd_pkg::ST_TRAILING;
          end else if (p_units + count > exp_units) begin
            p_err = prd_pkg::ST_OVERFLOW;
          end else begin
            p_run   = w.data[7];
            p_left  = count;
            p_phase = PH_VALUE;
          end
        end else if (p_phase == PH_VALUE && mode == prd_pkg::MODE_RGB565) begin
          p_low   = w.data;
          p_phase = PH_HIGH;
        end else begin
          r.pattern = 8'hff;
          if (p_phase == PH_HIGH) begin
            // a held low byte always completes as a direct color
            r.color_one = {w.data, p_low};
            mode = prd_pkg::MODE_RGB565;
          end else if (mode == prd_pkg::MODE_INDEX8) begin
            r.color_one = pal_mem[w.data];
          end else begin
            r.color_one  = pal_mem[1];
            r.color_zero = pal_mem[0];
            r.pattern    = w.data;
          end
          if (p_left == 0) p_left = 1;
          if (p_run) begin
            r.reps = 8'(p_left);
            p_left = 0;
          end else begin
            r.reps = 8'd1;
            p_left--;
          end
          p_phase = (p_left != 0) ? PH_VALUE : PH_TOKEN;
          if (mode == prd_pkg::MODE_INDEX1)
            r.fin_pixels = (p_units + r.reps == exp_units) ?
                           4'(((int'(cur_width) - 1) & 7) + 1) : 4'd8;
          else
            r.fin_pixels = 4'd1;
          p_units += r.reps;
          r.unit = 1'b1;
          has_unit = 1'b1;
        end
      end
    end
    if (w.last) begin
      r.row_end = 1'b1;
      if (p_err != prd_pkg::ST_OK) r.status = p_err;
      else if (p_phase != PH_TOKEN || p_units != exp_units) r.status = prd_pkg::ST_SHORT;
      else r.status = prd_pkg::ST_OK;
      clear_row_state();
    end
    return has_unit || w.last;
  endfunction

  function automatic in_word_t row_byte(logic [7:0] b, logic l);
    return '{prd_pkg::CMD_ROW, b, l, 8'($urandom), 16'($urandom)};
  endfunction

  function automatic in_word_t pal_word(logic [7:0] slot, logic [15:0] color);
    return '{prd_pkg::CMD_PALETTE, 8'($urandom), 1'($urandom), slot, color};
  endfunction

  function automatic out_word_t unit_res(logic [15:0] c1, logic [7:0] rep, logic fin_row);
    return '{1'b1, c1, 16'd0, 8'hff, rep, 4'd1, fin_row, prd_pkg::ST_OK};
  endfunction

  function automatic out_word_t end_res(logic [2:0] st);
    return '{1'b0, 16'd0, 16'd0, 8'd0, 8'd0, 4'd0, 1'b1, st};
  endfunction

  function automatic void add_row(dir_kind_t kind, logic [7:0] b, logic l, out_word_t res);
    dir_tab.push_back('{kind, row_byte(b, l), res, 1'b0, 12'd0});
  endfunction

  function automatic void add_cfg(logic idx, logic [11:0] val);
    dir_tab.push_back('{ROW_CFG, in_word_t'('0), out_word_t'('0), idx, val});
  endfunction

  function automatic void check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      errors++;
    end
  endfunction

  task automatic send_word(in_word_t w, dir_kind_t kind, out_word_t typed);
    out_word_t pred;
    bit        has_res;
    int        gap;
    gap = tx_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {w.color, w.slot, w.data};
    s_tuser  <= w.cmd;
    s_tlast  <= w.last;
    do @(posedge clk); while (!s_tready);
    has_res = decode_word(w, pred);
    if (kind == ROW_TYPED) pending_units.push_back(typed);
    else if (kind == ROW_PRED && has_res) pending_units.push_back(pred);
  endtask

  // words without a result may still be in flight when the queue empties
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_units.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [11:0] val);
    wait_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == prd_pkg::CFG_PIXEL_MODE) cur_mode = val[1:0];
    else cur_width = val;
  endtask

  task automatic build_row(row_shape_t shape);
    int unsigned exp_units, units, rem, cnt;
    logic [1:0]  mode;
    bit          run;
    row_bytes.delete();
    mode = (cur_mode == MODE_RGB565_ALT) ? prd_pkg::MODE_RGB565 : cur_mode;
    exp_units = (mode == prd_pkg::MODE_INDEX1) ? (int'(cur_width) + 7) / 8 : int'(cur_width);
    units = 0;
    if (shape == SH_NOISE) begin
      repeat ($urandom_range(1, 12)) row_bytes.push_back(8'($urandom));
    end else if (shape == SH_LONG) begin
      // four full literal tokens run past the row byte limit
      repeat (4) begin
        row_bytes.push_back(8'h7f);
        repeat (128) row_bytes.push_back(8'($urandom));
      end
    end else begin
      while (units < exp_units) begin
        rem = exp_units - units;
        if (shape == SH_OVER && rem < 128) begin
          row_bytes.push_back({1'($urandom), 7'($urandom_range(rem, 127))});
          repeat ($urandom_range(1, 3)) row_bytes.push_back(8'($urandom));
          break;
        end
        run = (exp_units > 64) ? ($urandom_range(0, 9) != 0) : 1'($urandom);
        if (run) cnt = (rem > 128) ? $urandom_range(32, 128) : $urandom_range(1, rem);
        else cnt = $urandom_range(1, (rem < 6) ? rem : 6);
        row_bytes.push_back({run, 7'(cnt - 1)});
        repeat (run ? 1 : cnt) begin
          row_bytes.push_back(8'($urandom));
          if (mode == prd_pkg::MODE_RGB565) row_bytes.push_back(8'($urandom));
        end
        units += cnt;
      end
      if (shape == SH_CUT && row_bytes.size() > 1)
        repeat ($urandom_range(1, (row_bytes.size() > 4) ? 4 : row_bytes.size() - 1))
          void'(row_bytes.pop_back());
      if (shape == SH_EXTRA)
        repeat ($urandom_range(1, 4)) row_bytes.push_back(8'($urandom));
      if (row_bytes.size() == 0) row_bytes.push_back(8'($urandom));
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tuser, m_tdata[15:0], m_tdata[31:16], m_tdata[39:32], m_tdata[47:40],
             m_tdata[51:48], m_tlast, m_tdata[54:52]};
      if (pending_units.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        want = pending_units.pop_front();
        check_field("unit_valid", 16'(want.unit), 16'(got.unit));
        check_field("color_one", want.color_one, got.color_one);
        check_field("color_zero", want.color_zero, got.color_zero);
        check_field("bit_pattern", 16'(want.pattern), 16'(got.pattern));
        check_field("repeat_count", 16'(want.reps), 16'(got.reps));
        check_field("final_unit_pixels", 16'(want.fin_pixels), 16'(got.fin_pixels));
        check_field("row_end", 16'(want.row_end), 16'(got.row_end));
        check_field("row_status", 16'(want.status), 16'(got.status));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // output side back-pressure
  initial begin
    int gap;
    wait (rst == 1'b0);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
      gap = rx_burst ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  initial begin
    int          words;
    int          row_no;
    int          pick;
    row_shape_t  shape;
    logic [11:0] width_val;

    cur_mode  = prd_pkg::MODE_RGB565;
    cur_width = 12'd1;
    clear_row_state();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // every palette entry gets a color before any lookup
    for (int i = 0; i < 256; i++) send_word(pal_word(8'(i), 16'($urandom)), ROW_PRED, '0);

    // right after reset: direct mode, one pixel per row
    add_row(ROW_NONE, 8'h00, 1'b0, '0);
    add_row(ROW_NONE, 8'h34, 1'b0, '0);
    add_row(ROW_TYPED, 8'h12, 1'b1, unit_res(16'h1234, 8'd1, 1'b1));
    add_row(ROW_NONE, 8'h00, 1'b0, '0);
    add_row(ROW_NONE, 8'hff, 1'b0, '0);
    add_row(ROW_TYPED, 8'hff, 1'b0, unit_res(16'hffff, 8'd1, 1'b0));
    add_row(ROW_TYPED, 8'h7f, 1'b1, end_res(prd_pkg::ST_TRAILING));
    // row ends inside a token
    add_row(ROW_TYPED, 8'h80, 1'b1, end_res(prd_pkg::ST_SHORT));
    // longest run
    add_cfg(prd_pkg::CFG_ROW_WIDTH, 12'd128);
    add_row(ROW_NONE, 8'hff, 1'b0, '0);
    add_row(ROW_NONE, 8'h00, 1'b0, '0);
    add_row(ROW_TYPED, 8'h00, 1'b1, unit_res(16'h0000, 8'd128, 1'b1));
    add_cfg(prd_pkg::CFG_ROW_WIDTH, 12'd5);
    add_row(ROW_NONE, 8'h85, 1'b0, '0);
    add_row(ROW_TYPED, 8'h00, 1'b1, end_res(prd_pkg::ST_OVERFLOW));
    // zero width: every byte is trailing
    add_cfg(prd_pkg::CFG_ROW_WIDTH, 12'd0);
    add_row(ROW_TYPED, 8'h00, 1'b1, end_res(prd_pkg::ST_TRAILING));
    add_cfg(prd_pkg::CFG_PIXEL_MODE, 12'(prd_pkg::MODE_INDEX8));
    add_cfg(prd_pkg::CFG_ROW_WIDTH, 12'd3);
    add_row(ROW_NONE, 8'h02, 1'b0, '0);
    add_row(ROW_PRED, 8'h00, 1'b0, '0);
    add_row(ROW_PRED, 8'hff, 1'b0, '0);
    add_row(ROW_PRED, 8'h01, 1'b1, '0);
    add_cfg(prd_pkg::CFG_PIXEL_MODE, 12'(prd_pkg::MODE_INDEX1));
    add_cfg(prd_pkg::CFG_ROW_WIDTH, 12'd9);
    add_row(ROW_NONE, 8'h81, 1'b0, '0);
    add_row(ROW_PRED, 8'ha5, 1'b1, '0);
    // palette write inside a row, its last flag must be ignored
    add_cfg(prd_pkg::CFG_ROW_WIDTH, 12'd16);
    add_row(ROW_NONE, 8'h01, 1'b0, '0);
    add_row(ROW_PRED, 8'h00, 1'b0, '0);
    dir_tab.push_back('{ROW_PRED,
                      in_word_t'({prd_pkg::CMD_PALETTE, 8'h5a, 1'b1, 8'd1, 16'hbeef}),
                      out_word_t'('0), 1'b0, 12'd0});
    add_row(ROW_PRED, 8'hff, 1'b1, '0);
    // mode three behaves as direct; mode change while the high byte is pending
    add_cfg(prd_pkg::CFG_PIXEL_MODE, 12'hfff);
    add_cfg(prd_pkg::CFG_ROW_WIDTH, 12'd1);
    add_row(ROW_NONE, 8'h80, 1'b0, '0);
    add_row(ROW_NONE, 8'hcd, 1'b0, '0);
    add_cfg(prd_pkg::CFG_PIXEL_MODE, 12'(prd_pkg::MODE_INDEX8));
    add_row(ROW_TYPED, 8'hab, 1'b1, unit_res(16'habcd, 8'd1, 1'b1));

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) write_reg(dir_tab[i].cfg_idx, dir_tab[i].cfg_val);
      else send_word(dir_tab[i].w, dir_tab[i].kind, dir_tab[i].res);
    end

    words  = 0;
    row_no = 0;
    while (words < RAND_WORDS) begin
      if (row_no == 3) begin
        write_reg(prd_pkg::CFG_PIXEL_MODE, 12'(prd_pkg::MODE_INDEX8));
        write_reg(prd_pkg::CFG_ROW_WIDTH, 12'd40);
      end else if (row_no == 12) begin
        write_reg(prd_pkg::CFG_PIXEL_MODE, 12'(prd_pkg::MODE_INDEX8));
        write_reg(prd_pkg::CFG_ROW_WIDTH, 12'd4095);
      end else if ($urandom_range(0, 3) == 0) begin
        pick = $urandom_range(0, 19);
        width_val = (pick < 12) ? 12'($urandom_range(1, 24)) :
                    (pick < 15) ? 12'($urandom_range(25, 300)) :
                    (pick < 17) ? 12'd4095 :
                    (pick < 18) ? 12'd0 : 12'($urandom_range(1, 8));
        pick = $urandom_range(0, 2);
        if (pick != 1) write_reg(prd_pkg::CFG_PIXEL_MODE, {10'($urandom), 2'($urandom)});
        if (pick != 0) write_reg(prd_pkg::CFG_ROW_WIDTH, width_val);
      end
      // sender stops until the output side has caught up
      if (row_no == 8) wait_idle();
      pick = $urandom_range(0, 99);
      shape = (row_no == 3)  ? SH_GOOD :
              (row_no == 12) ? SH_LONG :
              (pick < 70) ? SH_GOOD : (pick < 78) ? SH_CUT : (pick < 86) ? SH_EXTRA :
              (pick < 93) ? SH_OVER : SH_NOISE;
      tx_burst = (row_no == 3) || ($urandom_range(0, 4) == 0);
      // long output stall while the sender keeps offering words
      if (row_no == 3) hold_req = 1'b1;
      build_row(shape);
      foreach (row_bytes[i]) begin
        if ($urandom_range(0, 24) == 0) begin
          send_word(pal_word(8'($urandom), 16'($urandom)), ROW_PRED, '0);
          words++;
        end
        send_word(row_byte(row_bytes[i], i == row_bytes.size() - 1), ROW_PRED, '0);
      end
      words += row_bytes.size();
      row_no++;
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
